// ----- rtl/cartridge_bank_mapper_with_chr_latch_defines.svh -----
// ----------------------------------------------------------------------------
// Cartridge bank mapper assertion macros
// Shared property forms for the checks at the end of the mapper top level.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_WITH_CHR_LATCH_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_CHR_LATCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cartridge mapper check failed");

// The consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cartridge mapper check failed");

`endif

// ----- rtl/cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Widths, access codes, window and trigger addresses, and shared structs.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int ROM_ADDR_W = 18;
   localparam int PRG_BANK_W = 4;
   localparam int CHR_BANK_W = 5;
   localparam int COUNT_W    = 5;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   // Bus access kinds.
   typedef enum logic [1:0] {
      REQ_CPU_READ  = 2'd0,
      REQ_CPU_WRITE = 2'd1,
      REQ_PPU_READ  = 2'd2,
      REQ_PPU_WRITE = 2'd3
   } req_kind_type;

   // Register byte addresses.
   localparam logic [CSR_ADDR_W-1:0] CSR_PRG_BANK_COUNT = '0;
   localparam logic [COUNT_W-1:0]    PRG_BANK_COUNT_RESET = 5'd16;

   // CPU write windows, by the top address nibble.
   localparam logic [3:0] WIN_PRG_BANK    = 4'hA;
   localparam logic [3:0] WIN_CHR_LOW_FD  = 4'hB;
   localparam logic [3:0] WIN_CHR_LOW_FE  = 4'hC;
   localparam logic [3:0] WIN_CHR_HIGH_FD = 4'hD;
   localparam logic [3:0] WIN_CHR_HIGH_FE = 4'hE;
   localparam logic [3:0] WIN_MIRROR      = 4'hF;

   // Latch trigger addresses. The high latch compares on 8-byte ranges.
   localparam logic [ADDR_W-1:0] LATCH_LOW_FD_ADDR  = 16'h0FD8;
   localparam logic [ADDR_W-1:0] LATCH_LOW_FE_ADDR  = 16'h0FE8;
   localparam logic [ADDR_W-1:0] LATCH_HIGH_FD_ADDR = 16'h1FD8;
   localparam logic [ADDR_W-1:0] LATCH_HIGH_FE_ADDR = 16'h1FE8;

   typedef struct packed {
      req_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic                  hit;
      logic                  rom_select;
      logic [ROM_ADDR_W-1:0] rom_addr;
      logic                  mirror_horizontal;
   } result_type;

   typedef struct packed {
      logic [PRG_BANK_W-1:0] prg_bank_sel;
      logic [CHR_BANK_W-1:0] chr_bank_low_fd;
      logic [CHR_BANK_W-1:0] chr_bank_low_fe;
      logic [CHR_BANK_W-1:0] chr_bank_high_fd;
      logic [CHR_BANK_W-1:0] chr_bank_high_fe;
      logic                  latch_low_is_fe;
      logic                  latch_high_is_fe;
      logic                  mirror_mode;
   } bank_state_type;

endpackage

// ----- rtl/cbm_csr.sv -----
// ----------------------------------------------------------------------------
// Cartridge bank mapper register port
// APB-style access to the program bank count register.
// ----------------------------------------------------------------------------
module cbm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cbm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cbm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cbm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [cbm_pkg::COUNT_W-1:0]    prg_bank_count
);
   import cbm_pkg::*;

   logic               write_en;
   logic [COUNT_W-1:0] prg_bank_count_ff;
   logic [COUNT_W-1:0] prg_bank_count_in;

   // A write completes in the access phase; the port never waits.
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Next value of the bank count register.
   always_comb begin
      prg_bank_count_in = prg_bank_count_ff;
      if (write_en && (csr_paddr == CSR_PRG_BANK_COUNT)) begin
         prg_bank_count_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_bank_count_ff <= PRG_BANK_COUNT_RESET;
      end else begin
         prg_bank_count_ff <= prg_bank_count_in;
      end
   end

   // Read data mux.
   always_comb begin
      case (csr_paddr)
         CSR_PRG_BANK_COUNT: begin
            csr_prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, prg_bank_count_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign prg_bank_count = prg_bank_count_ff;

endmodule

// ----- rtl/cbm_core.sv -----
// ----------------------------------------------------------------------------
// Cartridge bank mapper core
// Bank and latch registers with the decode that maps one bus access.
// ----------------------------------------------------------------------------
module cbm_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  cbm_pkg::req_item_type       item,
   input  logic [cbm_pkg::COUNT_W-1:0] prg_bank_count,
   output cbm_pkg::result_type         result,
   output cbm_pkg::bank_state_type     state
);
   import cbm_pkg::*;

   bank_state_type        state_ff;
   bank_state_type        state_in;
   logic [COUNT_W-1:0]    count_minus_one;
   logic [PRG_BANK_W-1:0] fixed_bank;
   logic [PRG_BANK_W-1:0] cpu_bank;
   logic [CHR_BANK_W-1:0] chr_bank;

   // The fixed bank at C000 is the last one, wrapped to the bank width.
   assign count_minus_one = prg_bank_count - COUNT_W'(1);
   assign fixed_bank      = count_minus_one[PRG_BANK_W-1:0];

   // Decode the access, update banks and latches, and form the result.
   always_comb begin
      state_in = state_ff;
      result   = '0;
      cpu_bank = state_ff.prg_bank_sel;
      chr_bank = state_ff.chr_bank_low_fe;
      case (item.kind)
         REQ_CPU_READ: begin
            if (item.addr[15]) begin
               cpu_bank        = item.addr[14] ? fixed_bank : state_ff.prg_bank_sel;
               result.hit      = 1'b1;
               result.rom_addr = {cpu_bank, item.addr[13:0]};
            end
         end
         REQ_CPU_WRITE: begin
            case (item.addr[15:12])
               WIN_PRG_BANK: begin
                  state_in.prg_bank_sel = item.write_data[PRG_BANK_W-1:0];
               end
               WIN_CHR_LOW_FD: begin
                  state_in.chr_bank_low_fd = item.write_data[CHR_BANK_W-1:0];
               end
               WIN_CHR_LOW_FE: begin
                  state_in.chr_bank_low_fe = item.write_data[CHR_BANK_W-1:0];
               end
               WIN_CHR_HIGH_FD: begin
                  state_in.chr_bank_high_fd = item.write_data[CHR_BANK_W-1:0];
               end
               WIN_CHR_HIGH_FE: begin
                  state_in.chr_bank_high_fe = item.write_data[CHR_BANK_W-1:0];
               end
               WIN_MIRROR: begin
                  state_in.mirror_mode = item.write_data[0];
               end
               default: begin
               end
            endcase
            result.hit = (item.addr[15:12] >= WIN_PRG_BANK);
         end
         REQ_PPU_READ: begin
            if (item.addr[15:13] == 3'b000) begin
               // The latch flips first, so the trigger read sees the new bank.
               if (!item.addr[12]) begin
                  if (item.addr == LATCH_LOW_FD_ADDR) begin
                     state_in.latch_low_is_fe = 1'b0;
                  end else if (item.addr == LATCH_LOW_FE_ADDR) begin
                     state_in.latch_low_is_fe = 1'b1;
                  end
                  chr_bank = state_in.latch_low_is_fe ? state_ff.chr_bank_low_fe
                                                      : state_ff.chr_bank_low_fd;
               end else begin
                  if (item.addr[ADDR_W-1:3] == LATCH_HIGH_FD_ADDR[ADDR_W-1:3]) begin
                     state_in.latch_high_is_fe = 1'b0;
                  end else if (item.addr[ADDR_W-1:3] == LATCH_HIGH_FE_ADDR[ADDR_W-1:3]) begin
                     state_in.latch_high_is_fe = 1'b1;
                  end
                  chr_bank = state_in.latch_high_is_fe ? state_ff.chr_bank_high_fe
                                                       : state_ff.chr_bank_high_fd;
               end
               result.hit        = 1'b1;
               result.rom_select = 1'b1;
               result.rom_addr   = {1'b0, chr_bank, item.addr[11:0]};
            end
         end
         default: begin
            // Pattern memory is read-only; a PPU write is not handled.
         end
      endcase
      result.mirror_horizontal = state_in.mirror_mode;
   end

   // State registers advance only when an access is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{latch_low_is_fe: 1'b1, latch_high_is_fe: 1'b1, default: '0};
      end else if (enable) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ----- rtl/cartridge_bank_mapper_with_chr_latch.sv -----
// ----------------------------------------------------------------------------
// Cartridge bank mapper with pattern latches
// Maps CPU and PPU bus accesses onto program and pattern ROM addresses.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake           Payload
//   req       in          req_valid/stall     req_type, req_addr, req_write_data
//   rsp       out         rsp_valid/stall     rsp_hit, rsp_rom_select,
//                                             rsp_rom_addr, rsp_mirror_horizontal
//   csr       in/out      APB psel/penable    prg_bank_count at byte address 0
//
// One request is taken per cycle while req_stall is low. It waits in the input
// register and its result moves to the result register, from which it is
// offered on rsp.
// The decode and the bank and latch update sit between those two registers.
// A stall on rsp holds the result register and backs up into the input
// register, which raises req_stall only while both are full and rsp is stalled.
// Reset is synchronous and returns all banks to zero and both latches to FE.
//
`include "cartridge_bank_mapper_with_chr_latch_defines.svh"

module cartridge_bank_mapper_with_chr_latch (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [cbm_pkg::ADDR_W-1:0]        req_addr,
   input  logic [cbm_pkg::DATA_W-1:0]        req_write_data,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic                              rsp_rom_select,
   output logic [cbm_pkg::ROM_ADDR_W-1:0]    rsp_rom_addr,
   output logic                              rsp_mirror_horizontal,
   // Register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cbm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cbm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import cbm_pkg::*;

   logic               in_valid_ff;
   logic               in_valid_in;
   req_item_type       in_item_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   result_type         rsp_result_ff;
   result_type         core_result;
   bank_state_type     core_state;
   logic               advance;
   logic               req_take;
   logic [COUNT_W-1:0] prg_bank_count;
   logic               rsp_miss;
   logic               rsp_blank;
   logic               low_fd_read;
   logic               mirror_write;
   logic               mirror_bit;
   logic               mirror_mode;

   cbm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .prg_bank_count (prg_bank_count)
   );

   // The request in the input register moves on when the result slot frees.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   cbm_core u_core (
      .clock          (clock),
      .reset          (reset),
      .enable         (advance),
      .item           (in_item_ff),
      .prg_bank_count (prg_bank_count),
      .result         (core_result),
      .state          (core_state)
   );

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{kind: req_kind_type'(req_type), addr: req_addr,
                         write_data: req_write_data};
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= core_result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_result_ff.hit;
   assign rsp_rom_select        = rsp_result_ff.rom_select;
   assign rsp_rom_addr          = rsp_result_ff.rom_addr;
   assign rsp_mirror_horizontal = rsp_result_ff.mirror_horizontal;

   // Terms used by the checks below.
   assign rsp_miss     = rsp_valid_ff && !rsp_result_ff.hit;
   assign rsp_blank    = (rsp_result_ff.rom_addr == '0) && !rsp_result_ff.rom_select;
   assign low_fd_read  = advance && (in_item_ff.kind == REQ_PPU_READ)
                         && (in_item_ff.addr == LATCH_LOW_FD_ADDR);
   assign mirror_write = advance && (in_item_ff.kind == REQ_CPU_WRITE)
                         && (in_item_ff.addr[15:12] == WIN_MIRROR);
   assign mirror_bit   = in_item_ff.write_data[0];
   assign mirror_mode  = core_state.mirror_mode;

   // Checks.
   `CBM_ASSERT_SAME(a_miss_is_blank, clock, reset, rsp_miss, rsp_blank)
   `CBM_ASSERT_NEXT(a_state_holds_when_idle, clock, reset, !advance, $stable(core_state))
   `CBM_ASSERT_NEXT(a_low_latch_to_fd, clock, reset, low_fd_read, !core_state.latch_low_is_fe)
   `CBM_ASSERT_NEXT(a_mirror_write, clock, reset, mirror_write, mirror_mode == $past(mirror_bit))

endmodule

// ----- verif/tb_cartridge_bank_mapper_with_chr_latch.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the cartridge bank mapper with pattern latches
// Drives CPU and PPU bus requests with random idling on both channels and
// predicts each result with a behavioral copy of the banks and latches, or takes it from the directed row.
// Each result is compared field by field, in order, with the prediction.
// The program bank count is rewritten between phases, including the edges
// where the fixed bank wraps.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_with_chr_latch;
   import cbm_pkg::*;

   localparam int CLK_HALF       = 10;
   localparam int RESET_CYCLES   = 6;
   localparam int PHASE_COUNT    = 7;
   localparam int PHASE_REQUESTS = 250;
   localparam int HOLD_CYCLES    = 64;
   localparam int STUCK_LIMIT    = 3000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int REPORT_LIMIT   = 10;
   localparam int DIRECTED_ROWS  = 25;

   // One directed row: the request and, where it is obvious, its result.
   typedef struct {
      req_item_type access;
      bit           fixed;
      result_type   outcome;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_type = REQ_CPU_READ;
   logic [ADDR_W-1:0]     req_addr = '0;
   logic [DATA_W-1:0]     req_write_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_hit;
   logic                  rsp_rom_select;
   logic [ROM_ADDR_W-1:0] rsp_rom_addr;
   logic                  rsp_mirror_horizontal;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predicted mapper state and the expected results still in flight.
   bank_state_type mapper_state;
   logic [COUNT_W-1:0] bank_count;
   result_type pending_results [$];

   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_toggle = 1'b0;
   int requests_sent = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int stuck_cycles = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{REQ_CPU_READ,   16'h8000, 8'h00}, 1'b1, '{1'b1, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_CPU_READ,   16'hFFFF, 8'hA5}, 1'b1, '{1'b1, 1'b0, 18'h3FFFF, 1'b0}},
      '{'{REQ_CPU_READ,   16'h7FFF, 8'h00}, 1'b1, '{1'b0, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_CPU_READ,   16'h0000, 8'hFF}, 1'b1, '{1'b0, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_PPU_READ,   16'h0000, 8'h00}, 1'b1, '{1'b1, 1'b1, 18'h00000, 1'b0}},
      '{'{REQ_PPU_READ,   16'h1FFF, 8'h00}, 1'b1, '{1'b1, 1'b1, 18'h00FFF, 1'b0}},
      '{'{REQ_PPU_READ,   16'h2000, 8'h00}, 1'b1, '{1'b0, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_PPU_READ,   16'hFFFF, 8'h00}, 1'b1, '{1'b0, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_PPU_WRITE,  16'h0FD8, 8'hFF}, 1'b1, '{1'b0, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_CPU_WRITE,  16'h9FFF, 8'hFF}, 1'b1, '{1'b0, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_CPU_WRITE,  16'hA000, 8'hFF}, 1'b1, '{1'b1, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_CPU_WRITE,  16'hB000, 8'hFF}, 1'b1, '{1'b1, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_CPU_WRITE,  16'hCABC, 8'h15}, 1'b1, '{1'b1, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_CPU_WRITE,  16'hD123, 8'hEA}, 1'b1, '{1'b1, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_CPU_WRITE,  16'hEFFF, 8'h1F}, 1'b1, '{1'b1, 1'b0, 18'h00000, 1'b0}},
      '{'{REQ_CPU_WRITE,  16'hF000, 8'hFF}, 1'b1, '{1'b1, 1'b0, 18'h00000, 1'b1}},
      '{'{REQ_CPU_READ,   16'hBFFF, 8'h00}, 1'b1, '{1'b1, 1'b0, 18'h3FFFF, 1'b1}},
      '{'{REQ_PPU_READ,   16'h0FD7, 8'h00}, 1'b0, '0},
      '{'{REQ_PPU_READ,   16'h0FD8, 8'h00}, 1'b0, '0},
      '{'{REQ_PPU_READ,   16'h0FD9, 8'h00}, 1'b0, '0},
      '{'{REQ_PPU_READ,   16'h0FE8, 8'h00}, 1'b0, '0},
      '{'{REQ_PPU_READ,   16'h1FDF, 8'h00}, 1'b0, '0},
      '{'{REQ_PPU_READ,   16'h1FEF, 8'h00}, 1'b0, '0},
      '{'{REQ_PPU_READ,   16'h1FD8, 8'h00}, 1'b0, '0},
      '{'{REQ_CPU_WRITE,  16'hFFFF, 8'hFE}, 1'b1, '{1'b1, 1'b0, 18'h00000, 1'b0}}
   };

   cartridge_bank_mapper_with_chr_latch u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (req_type),
      .req_addr              (req_addr),
      .req_write_data        (req_write_data),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hit               (rsp_hit),
      .rsp_rom_select        (rsp_rom_select),
      .rsp_rom_addr          (rsp_rom_addr),
      .rsp_mirror_horizontal (rsp_mirror_horizontal),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   // Free-running clock.
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Applies one bus access to the predicted state and returns its result.
   // Latch flips happen before the pattern bank is chosen.
   function automatic result_type map_access(input req_item_type access);
      result_type outcome;
      logic [PRG_BANK_W-1:0] cpu_bank;
      logic [CHR_BANK_W-1:0] chr_bank;
      outcome = '0;
      case (access.kind)
         REQ_CPU_READ: begin
            if (access.addr[15]) begin
               cpu_bank = access.addr[14] ? PRG_BANK_W'(bank_count - 1'b1)
                                          : mapper_state.prg_bank_sel;
               outcome.hit = 1'b1;
               outcome.rom_addr = {cpu_bank, access.addr[13:0]};
            end
         end
         REQ_CPU_WRITE: begin
            if (access.addr >= 16'hA000) begin
               case (access.addr[15:12])
                  WIN_PRG_BANK:    mapper_state.prg_bank_sel = access.write_data[3:0];
                  WIN_CHR_LOW_FD:  mapper_state.chr_bank_low_fd = access.write_data[4:0];
                  WIN_CHR_LOW_FE:  mapper_state.chr_bank_low_fe = access.write_data[4:0];
                  WIN_CHR_HIGH_FD: mapper_state.chr_bank_high_fd = access.write_data[4:0];
                  WIN_CHR_HIGH_FE: mapper_state.chr_bank_high_fe = access.write_data[4:0];
                  default:         mapper_state.mirror_mode = access.write_data[0];
               endcase
               outcome.hit = 1'b1;
            end
         end
         REQ_PPU_READ: begin
            if (access.addr[15:12] == 4'h0) begin
               if (access.addr == LATCH_LOW_FD_ADDR) begin
                  mapper_state.latch_low_is_fe = 1'b0;
               end else if (access.addr == LATCH_LOW_FE_ADDR) begin
                  mapper_state.latch_low_is_fe = 1'b1;
               end
               chr_bank = mapper_state.latch_low_is_fe ? mapper_state.chr_bank_low_fe
                                                       : mapper_state.chr_bank_low_fd;
               outcome.hit = 1'b1;
               outcome.rom_select = 1'b1;
               outcome.rom_addr = {1'b0, chr_bank, access.addr[11:0]};
            end else if (access.addr[15:12] == 4'h1) begin
               // The high latch compares on eight-byte ranges.
               if (access.addr[15:3] == LATCH_HIGH_FD_ADDR[15:3]) begin
                  mapper_state.latch_high_is_fe = 1'b0;
               end else if (access.addr[15:3] == LATCH_HIGH_FE_ADDR[15:3]) begin
                  mapper_state.latch_high_is_fe = 1'b1;
               end
               chr_bank = mapper_state.latch_high_is_fe ? mapper_state.chr_bank_high_fe
                                                        : mapper_state.chr_bank_high_fd;
               outcome.hit = 1'b1;
               outcome.rom_select = 1'b1;
               outcome.rom_addr = {1'b0, chr_bank, access.addr[11:0]};
            end
         end
         default: begin
            // Pattern memory is read-only, so a PPU write does nothing.
         end
      endcase
      outcome.mirror_horizontal = mapper_state.mirror_mode;
      return outcome;
   endfunction

   // Builds a random access, mostly well-formed, with triggers and windows
   // weighted up so that the latches and banks move often.
   function automatic req_item_type random_access();
      req_item_type access;
      int pick;
      pick = $urandom_range(0, 99);
      access.addr = ADDR_W'($urandom());
      access.write_data = DATA_W'($urandom());
      if (pick < 15) begin
         access.kind = REQ_CPU_READ;
         if ($urandom_range(0, 9) != 0) access.addr[15] = 1'b1;
      end else if (pick < 35) begin
         access.kind = REQ_CPU_WRITE;
         if ($urandom_range(0, 9) != 0) access.addr[15:12] = 4'($urandom_range(10, 15));
      end else if (pick < 80) begin
         access.kind = REQ_PPU_READ;
         case ($urandom_range(0, 9))
            0: access.addr = LATCH_LOW_FD_ADDR;
            1: access.addr = LATCH_LOW_FE_ADDR;
            2: access.addr = {LATCH_HIGH_FD_ADDR[15:3], 3'($urandom())};
            3: access.addr = {LATCH_HIGH_FE_ADDR[15:3], 3'($urandom())};
            4: access.addr = 16'h0FC0 + ADDR_W'($urandom_range(0, 63));
            5: access.addr = 16'h1FC0 + ADDR_W'($urandom_range(0, 63));
            6: access.addr[13] = 1'b1;
            default: access.addr[15:13] = 3'b000;
         endcase
      end else if (pick < 90) begin
         access.kind = REQ_PPU_WRITE;
         if ($urandom_range(0, 1) != 0) access.addr[15:13] = 3'b000;
      end else begin
         access.kind = req_kind_type'($urandom_range(0, 3));
      end
      return access;
   endfunction

   // Counts a mismatch and prints only the first few.
   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   // Offers one request after a random gap and records its expected result.
   task automatic offer_request(input req_item_type access, input bit fixed,
                                input result_type outcome);
      result_type predicted;
      while (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_type <= access.kind;
      req_addr <= access.addr;
      req_write_data <= access.write_data;
      do @(posedge clock); while (req_stall);
      predicted = map_access(access);
      pending_results.push_back(fixed ? outcome : predicted);
      requests_sent++;
   endtask

   // Stops offering requests until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Writes the program bank count and reads it back.
   task automatic set_bank_count(input logic [COUNT_W-1:0] count);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] readback;
      wdata = CSR_DATA_W'($urandom());
      wdata[COUNT_W-1:0] = count;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_PRG_BANK_COUNT;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      bank_count = count;
      // Read back in a second transfer.
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[COUNT_W-1:0] !== count) begin
         note_mismatch($sformatf("bank count readback expected %0d got %0d",
                                 count, readback[COUNT_W-1:0]));
      end
   endtask

   // Result side stall: random, or a long hold counted here once requested.
   bit hold_seen = 1'b0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf("result with nothing pending: hit %0b addr %05h",
                                    rsp_hit, rsp_rom_addr));
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit) begin
               note_mismatch($sformatf("hit expected %0b got %0b", want.hit, rsp_hit));
            end
            if (rsp_rom_select !== want.rom_select) begin
               note_mismatch($sformatf("rom_select expected %0b got %0b",
                                       want.rom_select, rsp_rom_select));
            end
            if (rsp_rom_addr !== want.rom_addr) begin
               note_mismatch($sformatf("rom_addr expected %05h got %05h",
                                       want.rom_addr, rsp_rom_addr));
            end
            if (rsp_mirror_horizontal !== want.mirror_horizontal) begin
               note_mismatch($sformatf("mirror_horizontal expected %0b got %0b",
                                       want.mirror_horizontal, rsp_mirror_horizontal));
            end
         end
      end
   end

   // Watchdog on cycles in which no transfer happens anywhere.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_psel && csr_penable)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Watchdog expired with %0d results pending.", pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Stimulus: directed rows, then random phases under changing bank counts.
   initial begin
      logic [COUNT_W-1:0] count_plan [PHASE_COUNT];
      count_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd16, 5'd1};
      count_plan[5] = COUNT_W'($urandom_range(2, 15));
      mapper_state = '0;
      mapper_state.latch_low_is_fe = 1'b1;
      mapper_state.latch_high_is_fe = 1'b1;
      bank_count = PRG_BANK_COUNT_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pass with the reset bank count.
      req_gap_pct = 18;
      rsp_stall_pct = 57;
      foreach (directed_rows[i]) begin
         offer_request(directed_rows[i].access, directed_rows[i].fixed,
                       directed_rows[i].outcome);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         set_bank_count(count_plan[phase]);
         if (phase < 2) begin
            req_gap_pct = 18;
            rsp_stall_pct = 57;
         end else if (phase < 4) begin
            req_gap_pct = 57;
            rsp_stall_pct = 18;
         end else begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         // Long result hold while requests keep coming, to back up the pipe.
         if (phase == 4) hold_toggle = ~hold_toggle;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (phase == 5 && n == PHASE_REQUESTS / 2) drain_results();
            offer_request(random_access(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      end
      $display("Ran %0d bus requests and checked %0d results across %0d bank counts,",
               requests_sent, results_seen, PHASE_COUNT + 1);
      $display("with idling on either side, a long result hold and %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_csr.sv
rtl/cbm_core.sv
rtl/cartridge_bank_mapper_with_chr_latch.sv
verif/tb_cartridge_bank_mapper_with_chr_latch.sv
